>>> sv/wme_pkg.sv
// ----------------------------------------------------------------------------
// wme_pkg
// shared codes, widths and types of the waveform min/max envelope block
// ----------------------------------------------------------------------------
`default_nettype none

package wme_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int TIME_W      = 40;
    localparam int WIN_W       = 22;
    localparam int COLCFG_W    = 12;
    localparam int SEL_W       = 12;
    localparam int CFG_W       = 22;
    localparam int OUT_USED_W  = 13;
    localparam int CUT_W       = TIME_W + 3;
    localparam int TST_W       = TIME_W + 2;
    localparam int PRUNE_SLACK = 2000;

    // operations
    localparam logic [1:0] OP_PUSH     = 2'd0;
    localparam logic [1:0] OP_DECIMATE = 2'd1;
    localparam logic [1:0] OP_RD_COL   = 2'd2;
    localparam logic [1:0] OP_RD_STAT  = 2'd3;

    // configuration register indexes
    localparam logic REG_COLUMN_COUNT = 1'b0;
    localparam logic REG_WINDOW_MS    = 1'b1;

    localparam logic [COLCFG_W-1:0] COLS_RESET = 12'd1024;
    localparam logic [WIN_W-1:0]    WIN_RESET  = 22'd10000;

    // datapath actions
    typedef logic [4:0] t_act;
    localparam t_act A_NONE     = 5'd0;
    localparam t_act A_LOAD     = 5'd1;
    localparam t_act A_CLR      = 5'd2;
    localparam t_act A_PUSH     = 5'd3;
    localparam t_act A_PR_RD    = 5'd4;
    localparam t_act A_PR_DROP  = 5'd5;
    localparam t_act A_DC_INIT  = 5'd6;
    localparam t_act A_TE_RD    = 5'd7;
    localparam t_act A_TE_SET   = 5'd8;
    localparam t_act A_P1_RD    = 5'd9;
    localparam t_act A_P1_ACC   = 5'd10;
    localparam t_act A_MN_GO    = 5'd11;
    localparam t_act A_MN_SET   = 5'd12;
    localparam t_act A_P2_RD    = 5'd13;
    localparam t_act A_P2_SKIP  = 5'd14;
    localparam t_act A_P2_MUL   = 5'd15;
    localparam t_act A_P2_DIV   = 5'd16;
    localparam t_act A_P2_BIN   = 5'd17;
    localparam t_act A_P2_BINW  = 5'd18;
    localparam t_act A_P2_COLRD = 5'd19;
    localparam t_act A_P2_AD    = 5'd20;
    localparam t_act A_P2_SQ    = 5'd21;
    localparam t_act A_P2_ACC   = 5'd22;
    localparam t_act A_P2_COLWR = 5'd23;
    localparam t_act A_RMS_GO   = 5'd24;
    localparam t_act A_SQ_GO    = 5'd25;
    localparam t_act A_RMS_SET  = 5'd26;
    localparam t_act A_RDC_RD   = 5'd27;
    localparam t_act A_OUT_COL  = 5'd28;
    localparam t_act A_OUT_STAT = 5'd29;

    typedef struct packed {
        logic fill_zero;
        logic k_done;
        logic in_win;
        logic prune_hit;
        logic used_zero;
        logic axis_last;
        logic clr_last;
        logic win_zero;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [TIME_W-1:0]           tm;
        logic [2:0][SAMPLE_BITS-1:0] smp;
    } t_ring;

    typedef struct packed {
        logic                        valid;
        logic [2:0][SAMPLE_BITS-1:0] mn;
        logic [2:0][SAMPLE_BITS-1:0] mx;
    } t_col;

endpackage

`default_nettype wire

>>> sv/wme_div.sv
// ----------------------------------------------------------------------------
// wme_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wme_div #(
    parameter int NW = 77,
    parameter int DW = 22
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_busy,
    output logic [NW-1:0]      o_quot
);
    localparam int CNW = $clog2(NW + 1);

    logic [NW-1:0]  r_q;
    logic [DW-1:0]  r_rem;
    logic [DW-1:0]  r_den;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic [DW:0]    rs;
    logic           ge;
    logic [DW:0]    diff;

    assign rs   = {r_rem, r_q[NW-1]};
    assign ge   = rs >= {1'b0, r_den};
    assign diff = rs - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], ge};
            r_rem <= ge ? diff[DW-1:0] : rs[DW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

`default_nettype wire

>>> sv/wme_sqrt.sv
// ----------------------------------------------------------------------------
// wme_sqrt
// integer square root of a 64 bit value, one root bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wme_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_val,
    output logic             o_busy,
    output logic [31:0]      o_root
);
    logic [63:0] r_n;
    logic [35:0] r_rem;
    logic [31:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [35:0] rem2;
    logic [35:0] trial;
    logic        ge;

    assign rem2  = {r_rem[33:0], r_n[63:62]};
    assign trial = {2'b00, r_root, 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd32;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n    <= {r_n[61:0], 2'b00};
            r_rem  <= ge ? rem2 - trial : rem2;
            r_root <= {r_root[30:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

`default_nettype wire

>>> sv/wme_ctrl.sv
// ----------------------------------------------------------------------------
// wme_ctrl
// sequencer: push and prune, decimate passes, reads and the clearing sweep
// ----------------------------------------------------------------------------
`default_nettype none

module wme_ctrl
    import wme_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_operation,
    input  wire t_sts       i_sts,
    output logic            o_stall,
    output t_act            o_act
);
    localparam logic [4:0] S_SWEEP    = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_PUSH     = 5'd2;
    localparam logic [4:0] S_PR_RD    = 5'd3;
    localparam logic [4:0] S_PR_WT    = 5'd4;
    localparam logic [4:0] S_DC_INIT  = 5'd5;
    localparam logic [4:0] S_DC_CLR   = 5'd6;
    localparam logic [4:0] S_TE_RD    = 5'd7;
    localparam logic [4:0] S_TE_WT    = 5'd8;
    localparam logic [4:0] S_P1_RD    = 5'd9;
    localparam logic [4:0] S_P1_WT    = 5'd10;
    localparam logic [4:0] S_MN_GO    = 5'd11;
    localparam logic [4:0] S_MN_WT    = 5'd12;
    localparam logic [4:0] S_P2_RD    = 5'd13;
    localparam logic [4:0] S_P2_WT    = 5'd14;
    localparam logic [4:0] S_P2_DIV   = 5'd15;
    localparam logic [4:0] S_P2_DWT   = 5'd16;
    localparam logic [4:0] S_P2_COLRD = 5'd17;
    localparam logic [4:0] S_P2_AD    = 5'd18;
    localparam logic [4:0] S_P2_SQ    = 5'd19;
    localparam logic [4:0] S_P2_ACC   = 5'd20;
    localparam logic [4:0] S_P2_COLWR = 5'd21;
    localparam logic [4:0] S_RMS_GO   = 5'd22;
    localparam logic [4:0] S_RMS_DWT  = 5'd23;
    localparam logic [4:0] S_RMS_SQ   = 5'd24;
    localparam logic [4:0] S_RDC_RD   = 5'd25;
    localparam logic [4:0] S_RDC_WT   = 5'd26;
    localparam logic [4:0] S_RDS      = 5'd27;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_act   = A_NONE;
        case (r_state)
            S_SWEEP: begin
                o_act = A_CLR;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_act = A_LOAD;
                    case (i_operation)
                        OP_PUSH:     n_state = S_PUSH;
                        OP_DECIMATE: n_state = S_DC_INIT;
                        OP_RD_COL:   n_state = S_RDC_RD;
                        default:     n_state = S_RDS;
                    endcase
                end
            end
            S_PUSH: begin
                o_act   = A_PUSH;
                n_state = S_PR_RD;
            end
            S_PR_RD: begin
                if (i_sts.fill_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_act   = A_PR_RD;
                    n_state = S_PR_WT;
                end
            end
            S_PR_WT: begin
                if (i_sts.prune_hit) begin
                    o_act   = A_PR_DROP;
                    n_state = S_PR_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DC_INIT: begin
                o_act   = A_DC_INIT;
                n_state = S_DC_CLR;
            end
            S_DC_CLR: begin
                o_act = A_CLR;
                if (i_sts.clr_last) n_state = i_sts.fill_zero ? S_IDLE : S_TE_RD;
            end
            S_TE_RD: begin
                o_act   = A_TE_RD;
                n_state = S_TE_WT;
            end
            S_TE_WT: begin
                o_act   = A_TE_SET;
                n_state = S_P1_RD;
            end
            S_P1_RD: begin
                if (i_sts.k_done) begin
                    n_state = i_sts.used_zero ? S_IDLE : S_MN_GO;
                end else begin
                    o_act   = A_P1_RD;
                    n_state = S_P1_WT;
                end
            end
            S_P1_WT: begin
                o_act   = A_P1_ACC;
                n_state = S_P1_RD;
            end
            S_MN_GO: begin
                o_act   = A_MN_GO;
                n_state = S_MN_WT;
            end
            S_MN_WT: begin
                if (i_sts.div_done) begin
                    o_act   = A_MN_SET;
                    n_state = i_sts.axis_last ? S_P2_RD : S_MN_GO;
                end
            end
            S_P2_RD: begin
                if (i_sts.k_done) begin
                    n_state = S_RMS_GO;
                end else begin
                    o_act   = A_P2_RD;
                    n_state = S_P2_WT;
                end
            end
            S_P2_WT: begin
                if (i_sts.in_win) begin
                    o_act   = A_P2_MUL;
                    n_state = S_P2_DIV;
                end else begin
                    o_act   = A_P2_SKIP;
                    n_state = S_P2_RD;
                end
            end
            S_P2_DIV: begin
                if (i_sts.win_zero) begin
                    o_act   = A_P2_BINW;
                    n_state = S_P2_COLRD;
                end else begin
                    o_act   = A_P2_DIV;
                    n_state = S_P2_DWT;
                end
            end
            S_P2_DWT: begin
                if (i_sts.div_done) begin
                    o_act   = A_P2_BIN;
                    n_state = S_P2_COLRD;
                end
            end
            S_P2_COLRD: begin
                o_act   = A_P2_COLRD;
                n_state = S_P2_AD;
            end
            S_P2_AD: begin
                o_act   = A_P2_AD;
                n_state = S_P2_SQ;
            end
            S_P2_SQ: begin
                o_act   = A_P2_SQ;
                n_state = S_P2_ACC;
            end
            S_P2_ACC: begin
                o_act   = A_P2_ACC;
                n_state = i_sts.axis_last ? S_P2_COLWR : S_P2_AD;
            end
            S_P2_COLWR: begin
                o_act   = A_P2_COLWR;
                n_state = S_P2_RD;
            end
            S_RMS_GO: begin
                o_act   = A_RMS_GO;
                n_state = S_RMS_DWT;
            end
            S_RMS_DWT: begin
                if (i_sts.div_done) begin
                    o_act   = A_SQ_GO;
                    n_state = S_RMS_SQ;
                end
            end
            S_RMS_SQ: begin
                if (i_sts.sqrt_done) begin
                    o_act   = A_RMS_SET;
                    n_state = i_sts.axis_last ? S_IDLE : S_RMS_GO;
                end
            end
            S_RDC_RD: begin
                o_act   = A_RDC_RD;
                n_state = S_RDC_WT;
            end
            S_RDC_WT: begin
                if (i_sts.out_free) begin
                    o_act   = A_OUT_COL;
                    n_state = S_IDLE;
                end
            end
            S_RDS: begin
                if (i_sts.out_free) begin
                    o_act   = A_OUT_STAT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/wme_dp.sv
// ----------------------------------------------------------------------------
// wme_dp
// datapath: sample ring, column memory, accumulators, divider and root unit
// ----------------------------------------------------------------------------
`default_nettype none

module wme_dp
    import wme_pkg::*;
#(
    parameter int RING_DEPTH  = 4096,
    parameter int MAX_COLUMNS = 4096
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_act                   i_act,
    output t_sts                        o_sts,
    input  wire logic [TIME_W-1:0]      i_sample_time,
    input  wire logic [SAMPLE_BITS-1:0] i_sample_x,
    input  wire logic [SAMPLE_BITS-1:0] i_sample_y,
    input  wire logic [SAMPLE_BITS-1:0] i_sample_z,
    input  wire logic [SEL_W-1:0]       i_select_index,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    input  wire logic                   i_stall,
    output logic                        o_valid,
    output logic [SAMPLE_BITS-1:0]      o_column_min_x,
    output logic [SAMPLE_BITS-1:0]      o_column_max_x,
    output logic [SAMPLE_BITS-1:0]      o_column_min_y,
    output logic [SAMPLE_BITS-1:0]      o_column_max_y,
    output logic [SAMPLE_BITS-1:0]      o_column_min_z,
    output logic [SAMPLE_BITS-1:0]      o_column_max_z,
    output logic                        o_column_empty,
    output logic [31:0]                 o_axis_mean,
    output logic [31:0]                 o_axis_rms,
    output logic [31:0]                 o_axis_peak,
    output logic [OUT_USED_W-1:0]       o_samples_used
);
    localparam int SB  = SAMPLE_BITS;
    localparam int AW  = $clog2(RING_DEPTH);
    localparam int FW  = $clog2(RING_DEPTH + 1);
    localparam int CAW = $clog2(MAX_COLUMNS);
    localparam int CW  = $clog2(MAX_COLUMNS + 1);
    localparam int SW  = SB + FW;
    localparam int SQW = 64 + FW;
    localparam int NW  = SQW;
    localparam int PW  = TIME_W + 1 + CW;

    // configuration
    logic [COLCFG_W-1:0] r_colcfg;
    logic [WIN_W-1:0]    r_win;
    logic [CW-1:0]       cols_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colcfg <= COLS_RESET;
            r_win    <= WIN_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_COLUMN_COUNT) r_colcfg <= i_cfg_data[COLCFG_W-1:0];
            else                                 r_win    <= i_cfg_data[WIN_W-1:0];
        end
    end

    always_comb begin
        if (r_colcfg == '0)                         cols_eff = CW'(1);
        else if (32'(r_colcfg) > 32'(MAX_COLUMNS))  cols_eff = CW'(MAX_COLUMNS);
        else                                        cols_eff = CW'(r_colcfg);
    end

    // latched input word
    logic [TIME_W-1:0]    r_in_time;
    logic [2:0][SB-1:0]   r_in_smp;
    logic [SEL_W-1:0]     r_in_sel;

    // ring state
    t_ring              r_ring [RING_DEPTH];
    t_ring              r_ring_rd;
    logic [AW-1:0]      r_head;
    logic [FW-1:0]      r_fill;
    logic [FW-1:0]      r_k;
    logic [CUT_W-1:0]   r_cutoff;
    logic [TST_W-1:0]   r_tstart;

    // column memory
    t_col               r_colm [MAX_COLUMNS];
    t_col               r_col_rd;
    logic [CAW-1:0]     r_idx;
    logic [CAW-1:0]     r_bin;

    // accumulators and stats
    logic [FW-1:0]          r_used;
    logic [2:0][SW-1:0]     r_sum;
    logic [2:0][SQW-1:0]    r_sumsq;
    logic [2:0][31:0]       r_mean;
    logic [2:0][31:0]       r_rms;
    logic [2:0][31:0]       r_peak;
    logic [FW-1:0]          r_used_total;
    logic [1:0]             r_ax;
    logic [PW-1:0]          r_prod;
    logic [31:0]            r_ad;
    logic [63:0]            r_sq;

    // output word
    logic               r_o_valid;
    logic [2:0][SB-1:0] r_o_mn;
    logic [2:0][SB-1:0] r_o_mx;
    logic               r_o_empty;
    logic [31:0]        r_o_mean;
    logic [31:0]        r_o_rms;
    logic [31:0]        r_o_peak;
    logic [FW-1:0]      r_o_used;

    // ring address arithmetic
    logic [AW+1:0] old_sum;
    logic [AW-1:0] oldest;
    logic [AW+1:0] walk_sum;
    logic [AW-1:0] walk;
    logic [AW-1:0] prev_head;
    logic [AW-1:0] head_inc;

    assign old_sum  = (AW+2)'(r_head) + (AW+2)'(RING_DEPTH) - (AW+2)'(r_fill);
    assign oldest   = (old_sum >= (AW+2)'(RING_DEPTH)) ? AW'(old_sum - (AW+2)'(RING_DEPTH))
                                                       : AW'(old_sum);
    assign walk_sum = (AW+2)'(oldest) + (AW+2)'(r_k);
    assign walk     = (walk_sum >= (AW+2)'(RING_DEPTH)) ? AW'(walk_sum - (AW+2)'(RING_DEPTH))
                                                        : AW'(walk_sum);
    assign prev_head = (r_head == '0) ? AW'(RING_DEPTH - 1) : r_head - 1'b1;
    assign head_inc  = (r_head == AW'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;

    logic          ring_re;
    logic [AW-1:0] ring_ra;
    t_ring         ring_wd;

    always_comb begin
        ring_re = 1'b1;
        case (i_act)
            A_PR_RD:          ring_ra = oldest;
            A_TE_RD:          ring_ra = prev_head;
            A_P1_RD, A_P2_RD: ring_ra = walk;
            default: begin
                ring_re = 1'b0;
                ring_ra = walk;
            end
        endcase
        ring_wd.tm  = r_in_time;
        ring_wd.smp = r_in_smp;
    end

    always_ff @(posedge i_clk) begin
        if (i_act == A_PUSH) r_ring[r_head] <= ring_wd;
        if (ring_re)         r_ring_rd      <= r_ring[ring_ra];
    end

    // window tests on the word just read
    logic in_win;
    logic prune_hit;
    assign in_win    = $signed({2'b00, r_ring_rd.tm}) >= $signed(r_tstart);
    assign prune_hit = $signed({3'b000, r_ring_rd.tm}) < $signed(r_cutoff);

    // column memory access
    logic           sel_in_range;
    logic [CAW-1:0] sel_addr;
    logic           col_we;
    logic [CAW-1:0] col_wa;
    t_col           col_wd;
    t_col           col_new;
    logic           col_re;
    logic [CAW-1:0] col_ra;

    assign sel_in_range = 32'(r_in_sel) < 32'(MAX_COLUMNS);
    assign sel_addr     = CAW'(r_in_sel);

    always_comb begin
        col_new.valid = 1'b1;
        for (int a = 0; a < 3; a++) begin
            col_new.mn[a] = (!r_col_rd.valid ||
                             $signed(r_ring_rd.smp[a]) < $signed(r_col_rd.mn[a]))
                            ? r_ring_rd.smp[a] : r_col_rd.mn[a];
            col_new.mx[a] = (!r_col_rd.valid ||
                             $signed(r_ring_rd.smp[a]) > $signed(r_col_rd.mx[a]))
                            ? r_ring_rd.smp[a] : r_col_rd.mx[a];
        end
        col_we = (i_act == A_CLR) || (i_act == A_P2_COLWR);
        col_wa = (i_act == A_CLR) ? r_idx : r_bin;
        col_wd = (i_act == A_CLR) ? t_col'('0) : col_new;
        col_re = (i_act == A_P2_COLRD) || (i_act == A_RDC_RD);
        col_ra = (i_act == A_RDC_RD) ? sel_addr : r_bin;
    end

    always_ff @(posedge i_clk) begin
        if (col_we) r_colm[col_wa] <= col_wd;
        if (col_re) r_col_rd       <= r_colm[col_ra];
    end

    // shared divider and root unit
    logic          div_start;
    logic [NW-1:0] div_num;
    logic [WIN_W-1:0] div_den;
    logic          div_busy;
    logic [NW-1:0] div_quot;
    logic          sq_busy;
    logic [31:0]   sq_root;

    logic [SW-1:0] sum_ax;
    logic          sum_neg;
    logic [SW-1:0] sum_mag;

    assign sum_ax  = r_sum[r_ax];
    assign sum_neg = sum_ax[SW-1];
    assign sum_mag = sum_neg ? (~sum_ax + 1'b1) : sum_ax;

    always_comb begin
        div_start = 1'b1;
        div_den   = WIN_W'(r_used);
        case (i_act)
            A_MN_GO:  div_num = (NW'(sum_mag) << 8) + NW'(r_used >> 1);
            A_P2_DIV: begin
                div_num = NW'(r_prod);
                div_den = r_win;
            end
            A_RMS_GO: div_num = r_sumsq[r_ax];
            default: begin
                div_start = 1'b0;
                div_num   = r_sumsq[r_ax];
            end
        endcase
    end

    wme_div #(.NW(NW), .DW(WIN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    wme_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_act == A_SQ_GO),
        .i_val   (div_quot[63:0]),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    // mean rounding and saturation
    logic [31:0] mean_val;
    always_comb begin
        if (!sum_neg) begin
            mean_val = (div_quot > NW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_quot[31:0];
        end else begin
            mean_val = (div_quot > NW'(32'h8000_0000)) ? 32'h8000_0000
                                                       : (~div_quot[31:0] + 1'b1);
        end
    end

    // deviation of the current axis from its mean, saturated magnitude
    logic [33:0] v_ext;
    logic [33:0] dev;
    logic [33:0] dev_abs;
    logic [31:0] ad_val;
    logic [SB-1:0] v_cur;

    assign v_cur   = r_ring_rd.smp[r_ax];
    assign v_ext   = {{(34-SB){v_cur[SB-1]}}, v_cur};
    assign dev     = (v_ext << 8) - {{2{r_mean[r_ax][31]}}, r_mean[r_ax]};
    assign dev_abs = dev[33] ? (~dev + 1'b1) : dev;
    assign ad_val  = (dev_abs[33:32] != 2'b00) ? 32'hFFFF_FFFF : dev_abs[31:0];

    // column from time offset
    logic [TST_W-1:0] tdiff;
    logic [PW-1:0]    prod;
    logic [CAW-1:0]   last_col;

    assign tdiff    = {2'b00, r_ring_rd.tm} - r_tstart;
    assign prod     = tdiff[TIME_W:0] * cols_eff;
    assign last_col = CAW'(cols_eff - 1'b1);

    logic [1:0] ax_inc;
    assign ax_inc = (r_ax == 2'd2) ? 2'd0 : r_ax + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_fill       <= '0;
            r_idx        <= '0;
            r_ax         <= '0;
            r_mean       <= '0;
            r_rms        <= '0;
            r_peak       <= '0;
            r_used_total <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (!i_stall) r_o_valid <= 1'b0;
            case (i_act)
                A_LOAD: begin
                    r_in_time   <= i_sample_time;
                    r_in_smp[0] <= i_sample_x;
                    r_in_smp[1] <= i_sample_y;
                    r_in_smp[2] <= i_sample_z;
                    r_in_sel    <= i_select_index;
                end
                A_CLR: begin
                    r_idx <= (r_idx == CAW'(MAX_COLUMNS - 1)) ? '0 : r_idx + 1'b1;
                end
                A_PUSH: begin
                    r_head   <= head_inc;
                    if (r_fill != FW'(RING_DEPTH)) r_fill <= r_fill + 1'b1;
                    r_cutoff <= {3'b000, r_in_time} - CUT_W'(r_win) - CUT_W'(PRUNE_SLACK);
                end
                A_PR_DROP: r_fill <= r_fill - 1'b1;
                A_DC_INIT: begin
                    r_mean       <= '0;
                    r_rms        <= '0;
                    r_peak       <= '0;
                    r_used_total <= '0;
                    r_used       <= '0;
                    r_sum        <= '0;
                    r_sumsq      <= '0;
                    r_ax         <= '0;
                    r_idx        <= '0;
                end
                A_TE_SET: begin
                    r_tstart <= {2'b00, r_ring_rd.tm} - TST_W'(r_win);
                    r_k      <= '0;
                end
                A_P1_ACC: begin
                    if (in_win) begin
                        r_used <= r_used + 1'b1;
                        for (int a = 0; a < 3; a++) begin
                            r_sum[a] <= r_sum[a] +
                                {{FW{r_ring_rd.smp[a][SB-1]}}, r_ring_rd.smp[a]};
                        end
                    end
                    r_k <= r_k + 1'b1;
                end
                A_MN_SET: begin
                    r_mean[r_ax] <= mean_val;
                    r_peak[r_ax] <= 32'd1;
                    r_ax         <= ax_inc;
                    r_k          <= '0;
                end
                A_P2_SKIP: r_k <= r_k + 1'b1;
                A_P2_MUL:  r_prod <= prod;
                A_P2_BIN: begin
                    r_bin <= (div_quot >= NW'(cols_eff)) ? last_col : CAW'(div_quot);
                end
                A_P2_BINW: r_bin <= last_col;
                A_P2_AD:   r_ad <= ad_val;
                A_P2_SQ: begin
                    r_sq <= r_ad * r_ad;
                    if (r_ad > r_peak[r_ax]) r_peak[r_ax] <= r_ad;
                end
                A_P2_ACC: begin
                    r_sumsq[r_ax] <= r_sumsq[r_ax] + SQW'(r_sq);
                    r_ax          <= ax_inc;
                end
                A_P2_COLWR: r_k <= r_k + 1'b1;
                A_RMS_SET: begin
                    r_rms[r_ax] <= sq_root;
                    r_ax        <= ax_inc;
                    if (r_ax == 2'd2) r_used_total <= r_used;
                end
                A_OUT_COL: begin
                    r_o_valid <= 1'b1;
                    r_o_mean  <= '0;
                    r_o_rms   <= '0;
                    r_o_peak  <= '0;
                    r_o_used  <= r_used_total;
                    if (sel_in_range && r_col_rd.valid) begin
                        r_o_mn    <= r_col_rd.mn;
                        r_o_mx    <= r_col_rd.mx;
                        r_o_empty <= 1'b0;
                    end else begin
                        r_o_mn    <= '0;
                        r_o_mx    <= '0;
                        r_o_empty <= 1'b1;
                    end
                end
                A_OUT_STAT: begin
                    r_o_valid <= 1'b1;
                    r_o_mn    <= '0;
                    r_o_mx    <= '0;
                    r_o_empty <= 1'b0;
                    r_o_used  <= r_used_total;
                    if (r_in_sel < SEL_W'(3)) begin
                        r_o_mean <= r_mean[r_in_sel[1:0]];
                        r_o_rms  <= r_rms[r_in_sel[1:0]];
                        r_o_peak <= r_peak[r_in_sel[1:0]];
                    end else begin
                        r_o_mean <= '0;
                        r_o_rms  <= '0;
                        r_o_peak <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_sts.fill_zero = (r_fill == '0);
        o_sts.k_done    = (r_k == r_fill);
        o_sts.in_win    = in_win;
        o_sts.prune_hit = prune_hit;
        o_sts.used_zero = (r_used == '0);
        o_sts.axis_last = (r_ax == 2'd2);
        o_sts.clr_last  = (r_idx == CAW'(MAX_COLUMNS - 1));
        o_sts.win_zero  = (r_win == '0);
        o_sts.div_done  = !div_busy;
        o_sts.sqrt_done = !sq_busy;
        o_sts.out_free  = !r_o_valid || !i_stall;
    end

    assign o_valid        = r_o_valid;
    assign o_column_min_x = r_o_mn[0];
    assign o_column_max_x = r_o_mx[0];
    assign o_column_min_y = r_o_mn[1];
    assign o_column_max_y = r_o_mx[1];
    assign o_column_min_z = r_o_mn[2];
    assign o_column_max_z = r_o_mx[2];
    assign o_column_empty = r_o_empty;
    assign o_axis_mean    = r_o_mean;
    assign o_axis_rms     = r_o_rms;
    assign o_axis_peak    = r_o_peak;
    assign o_samples_used = OUT_USED_W'(r_o_used);

endmodule

`default_nettype wire

>>> sv/waveform_minmax_envelope.sv
// ----------------------------------------------------------------------------
// waveform_minmax_envelope
// min/max column envelope and per-axis mean, rms and peak of one sample stream
// ----------------------------------------------------------------------------
// usage
//   input channel (i_valid / o_stall) carries one word per operation: push a
//   timestamped x/y/z sample, decimate the ring into columns, read a column,
//   or read one axis of statistics. only the two read operations produce a
//   word on the output channel (o_valid / i_stall), in request order
//   one word is worked on at a time; o_stall is high while it is in progress
//   push: store the sample, then drop entries from the old end of the ring
//   read column, read statistics: each may wait for the output register
//   decimate: column clear (one entry a cycle), a sum pass over the ring
//     entries, a mean divide per axis, then per windowed sample a column
//     divide on the shared bit-serial divider and per-axis work on one
//     multiplier, then rms per axis (divide then square root)
//   after reset the column memory is cleared with o_stall
//   high; configuration writes are taken at any time but belong in idle
//   a result waits in the output register while i_stall is high; the next
//   read finishes its work and then holds until that register frees up
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_minmax_envelope
    import wme_pkg::*;
#(
    parameter int RING_DEPTH  = 4096,
    parameter int MAX_COLUMNS = 4096
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input channel
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [1:0]             i_operation,
    input  wire logic [TIME_W-1:0]      i_sample_time,
    input  wire logic [SAMPLE_BITS-1:0] i_sample_x,
    input  wire logic [SAMPLE_BITS-1:0] i_sample_y,
    input  wire logic [SAMPLE_BITS-1:0] i_sample_z,
    input  wire logic [SEL_W-1:0]       i_select_index,
    // configuration writes
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    // output channel
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [SAMPLE_BITS-1:0]      o_column_min_x,
    output logic [SAMPLE_BITS-1:0]      o_column_max_x,
    output logic [SAMPLE_BITS-1:0]      o_column_min_y,
    output logic [SAMPLE_BITS-1:0]      o_column_max_y,
    output logic [SAMPLE_BITS-1:0]      o_column_min_z,
    output logic [SAMPLE_BITS-1:0]      o_column_max_z,
    output logic                        o_column_empty,
    output logic [31:0]                 o_axis_mean,
    output logic [31:0]                 o_axis_rms,
    output logic [31:0]                 o_axis_peak,
    output logic [OUT_USED_W-1:0]       o_samples_used
);
    // controller to datapath: one action code per cycle
    t_act act;
    // datapath to controller: compare results and unit status
    t_sts sts;

    wme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_stall     (o_stall),
        .o_act       (act)
    );

    // ring, column memory, accumulators and output word register
    wme_dp #(
        .RING_DEPTH  (RING_DEPTH),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_act          (act),
        .o_sts          (sts),
        .i_sample_time  (i_sample_time),
        .i_sample_x     (i_sample_x),
        .i_sample_y     (i_sample_y),
        .i_sample_z     (i_sample_z),
        .i_select_index (i_select_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_column_min_x (o_column_min_x),
        .o_column_max_x (o_column_max_x),
        .o_column_min_y (o_column_min_y),
        .o_column_max_y (o_column_max_y),
        .o_column_min_z (o_column_min_z),
        .o_column_max_z (o_column_max_z),
        .o_column_empty (o_column_empty),
        .o_axis_mean    (o_axis_mean),
        .o_axis_rms     (o_axis_rms),
        .o_axis_peak    (o_axis_peak),
        .o_samples_used (o_samples_used)
    );

endmodule

`default_nettype wire
